@@ rtl/core/aes_cbc_pkg.sv @@
// Types, constants and AES byte functions for the AES-256 CBC block.
// No dependencies.
package aes_cbc_pkg;

    localparam logic [1:0] KIND_ENC     = 2'd0;
    localparam logic [1:0] KIND_DEC     = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_IVH   = 3'd4;
    localparam logic [2:0] REG_IVL   = 3'd5;

    localparam int NUM_ROUNDS = 14;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_item_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] ISBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Forward round without key: SubBytes, ShiftRows, optional MixColumns
    function automatic logic [127:0] enc_round(input logic [127:0] s, input logic mix);
        logic [7:0] b [16];
        logic [7:0] t [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) b[i] = SBOX[s[127-8*i -: 8]];
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++) t[r+4*c] = b[r+4*((c+r)&3)];
        for (int c = 0; c < 4; c++)
        begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            if (mix)
            begin
                t[4*c]   = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
                t[4*c+1] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
                t[4*c+2] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
                t[4*c+3] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
            end
        end
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = t[i];
        enc_round = o;
    endfunction

    // Inverse MixColumns on a full state
    function automatic logic [127:0] inv_mix(input logic [127:0] s);
        logic [7:0] a [4];
        logic [7:0] m2 [4];
        logic [7:0] m4 [4];
        logic [7:0] m8 [4];
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                a[r]  = s[127-8*(4*c+r) -: 8];
                m2[r] = xt(a[r]);
                m4[r] = xt(m2[r]);
                m8[r] = xt(m4[r]);
            end
            // 14=8+4+2, 11=8+2+1, 13=8+4+1, 9=8+1
            for (int r = 0; r < 4; r++)
                o[127-8*(4*c+r) -: 8] =
                    (m8[r] ^ m4[r] ^ m2[r]) ^
                    (m8[(r+1)&3] ^ m2[(r+1)&3] ^ a[(r+1)&3]) ^
                    (m8[(r+2)&3] ^ m4[(r+2)&3] ^ a[(r+2)&3]) ^
                    (m8[(r+3)&3] ^ a[(r+3)&3]);
        end
        inv_mix = o;
    endfunction

    // Inverse ShiftRows then inverse SubBytes
    function automatic logic [127:0] dec_sub(input logic [127:0] s);
        logic [7:0] t [16];
        logic [127:0] o;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[r+4*((c+r)&3)] = s[127-8*(r+4*c) -: 8];
        for (int i = 0; i < 16; i++) o[127-8*i -: 8] = ISBOX[t[i]];
        dec_sub = o;
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

endpackage

@@ rtl/core/aes_cbc_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module aes_cbc_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 15
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule

@@ rtl/core/aes256_cbc_cipher.sv @@
// AES-256 CBC top level: control sequencer, key expansion, round datapath.
// Uses aes_cbc_pkg and aes_cbc_ram.
//
// The core works on one item at a time. For encrypt and decrypt, the LOAD
// state does the whitening with the first round key, read at accept. Then the
// RND state runs the 14 rounds, one round per cycle, in a shared round unit,
// with one round-key read from the round-key RAM per cycle.
// A restart runs the KEXP state instead: the key schedule writes one 128-bit
// round key per cycle into the RAM (15 entries). An output register holds a
// waiting result. The next item can therefore be accepted on the cycle after
// the result is registered, and not before the last item is through. The input
// stalls beyond that only if a new result completes while the previous one
// still waits. Round keys read as zero until the first restart completes.
// Written key and IV values take effect only at a restart.
module aes256_cbc_cipher (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  aes_cbc_pkg::in_item_t  in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output aes_cbc_pkg::out_item_t out_data,
    input  logic                   cfg_we,
    input  logic [2:0]             cfg_index,
    input  logic [63:0]            cfg_data
);
    import aes_cbc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KEXP = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    // configuration registers
    logic [63:0] key_reg [4];
    logic [63:0] ivh_reg, ivl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            ivh_reg <= '0;
            ivl_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY0: key_reg[0] <= cfg_data;
                REG_KEY1: key_reg[1] <= cfg_data;
                REG_KEY2: key_reg[2] <= cfg_data;
                REG_KEY3: key_reg[3] <= cfg_data;
                REG_IVH:  ivh_reg    <= cfg_data;
                REG_IVL:  ivl_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [2:0]   state_reg;
    logic [3:0]   cnt_reg;
    logic         dec_reg;
    logic         keyed_reg;
    logic [127:0] st_reg;
    logic [127:0] blk_reg;
    logic [127:0] chain_reg;
    logic [127:0] res_reg;
    logic [127:0] res_next;
    logic         out_vld_reg;
    logic         out_free;
    logic         out_load;
    logic [255:0] kw_reg;     // last eight key schedule words
    logic [2:0]   rc_reg;     // rcon index

    // round-key RAM
    logic         rk_we;
    logic [3:0]   rk_waddr, rk_raddr;
    logic [127:0] rk_wdata, rk_rdata, rk;

    aes_cbc_ram #(.WIDTH(128), .DEPTH(15)) u_rk_ram (
        .clk     (clk),
        .wr_en   (rk_we),
        .wr_addr (rk_waddr),
        .wr_data (rk_wdata),
        .rd_addr (rk_raddr),
        .rd_data (rk_rdata)
    );

    assign rk = keyed_reg ? rk_rdata : '0;

    // key schedule: each step produces eight new words from the previous eight
    logic [31:0] nw [8];
    logic [31:0] t0, t4;
    logic [7:0]  rcon;
    always_comb
    begin
        case (rc_reg)
            3'd0: rcon = 8'h01;
            3'd1: rcon = 8'h02;
            3'd2: rcon = 8'h04;
            3'd3: rcon = 8'h08;
            3'd4: rcon = 8'h10;
            3'd5: rcon = 8'h20;
            default: rcon = 8'h40;
        endcase
        t0 = sub_word({kw_reg[23:0], kw_reg[31:24]}) ^ {rcon, 24'h0};
        nw[0] = kw_reg[255:224] ^ t0;
        for (int i = 1; i < 4; i++)
            nw[i] = kw_reg[255-32*i -: 32] ^ nw[i-1];
        t4 = sub_word(nw[3]);
        nw[4] = kw_reg[127:96] ^ t4;
        for (int i = 5; i < 8; i++)
            nw[i] = kw_reg[255-32*i -: 32] ^ nw[i-1];
    end

    // in KEXP, even count writes the first four words; odd count writes the last
    // four words of the current eight, after which the schedule steps
    always_comb
    begin
        rk_we    = 1'b0;
        rk_waddr = cnt_reg;
        rk_wdata = kw_reg[255:128];
        if (state_reg == ST_KEXP)
        begin
            rk_we    = 1'b1;
            rk_wdata = cnt_reg[0] ? kw_reg[127:0] : kw_reg[255:128];
        end
    end

    // read address: the key needed in the next cycle, as the read data is registered
    always_comb
    begin
        rk_raddr = '0;
        if (state_reg == ST_IDLE)
            rk_raddr = (in_data.kind == KIND_DEC) ? 4'(NUM_ROUNDS) : 4'd0;
        else if (state_reg == ST_LOAD)
            rk_raddr = dec_reg ? 4'(NUM_ROUNDS - 1) - cnt_reg : cnt_reg + 4'd1;
        else if (state_reg == ST_RND && !last)
            rk_raddr = dec_reg ? 4'(NUM_ROUNDS - 2) - cnt_reg : cnt_reg + 4'd2;
    end

    logic in_acc;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && (state_reg == ST_IDLE);
    assign out_valid = out_vld_reg;
    assign out_data  = res_reg;
    assign out_free  = !out_vld_reg || !out_stall;

    logic [127:0] rnd_out;
    logic         last;
    assign last = (cnt_reg == 4'(NUM_ROUNDS - 1));
    always_comb
    begin
        if (dec_reg)
            rnd_out = last ? (dec_sub(st_reg) ^ rk)
                           : inv_mix(dec_sub(st_reg) ^ rk);
        else
            rnd_out = enc_round(st_reg, !last) ^ rk;
    end

    // finished result and handover into the output register
    always_comb
    begin
        res_next = st_reg;
        out_load = 1'b0;
        case (state_reg)
            ST_KEXP:
            begin
                if (cnt_reg == 4'(NUM_ROUNDS))
                begin
                    res_next = '0;
                    out_load = out_free;
                end
            end
            ST_RND:
            begin
                if (last)
                begin
                    res_next = dec_reg ? (rnd_out ^ chain_reg) : rnd_out;
                    out_load = out_free;
                end
            end
            ST_OUT: out_load = out_free;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            res_reg     <= '0;
        end
        else if (out_load)
        begin
            out_vld_reg <= 1'b1;
            res_reg     <= res_next;
        end
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            dec_reg   <= 1'b0;
            keyed_reg <= 1'b0;
            chain_reg <= '0;
            rc_reg    <= '0;
            st_reg    <= '0;
            blk_reg   <= '0;
            kw_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_acc)
                    begin
                        blk_reg <= {in_data.block_high, in_data.block_low};
                        dec_reg <= (in_data.kind == KIND_DEC);
                        if (in_data.kind == KIND_RESTART)
                        begin
                            kw_reg    <= {key_reg[0], key_reg[1], key_reg[2], key_reg[3]};
                            rc_reg    <= '0;
                            chain_reg <= {ivh_reg, ivl_reg};
                            state_reg <= ST_KEXP;
                        end
                        else if (in_data.kind == KIND_ENC || in_data.kind == KIND_DEC)
                            state_reg <= ST_LOAD;
                    end
                end
                ST_KEXP:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg[0])
                    begin
                        kw_reg <= {nw[0], nw[1], nw[2], nw[3], nw[4], nw[5], nw[6], nw[7]};
                        rc_reg <= rc_reg + 3'd1;
                    end
                    if (cnt_reg == 4'(NUM_ROUNDS))
                    begin
                        keyed_reg <= 1'b1;
                        st_reg    <= res_next;
                        state_reg <= out_load ? ST_IDLE : ST_OUT;
                    end
                end
                ST_LOAD:
                begin
                    // whitening with the key read at accept
                    st_reg    <= (dec_reg ? blk_reg : blk_reg ^ chain_reg) ^ rk;
                    state_reg <= ST_RND;
                end
                ST_RND:
                begin
                    cnt_reg <= cnt_reg + 4'd1;
                    if (last)
                    begin
                        st_reg <= res_next;
                        if (dec_reg)
                            chain_reg <= blk_reg;
                        else
                            chain_reg <= rnd_out;
                        state_reg <= out_load ? ST_IDLE : ST_OUT;
                    end
                    else
                        st_reg <= rnd_out;
                end
                ST_OUT:
                begin
                    // result parked in st_reg until the output register frees
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input accepted while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(res_reg)))
        else $error("result changed while stalled");
    a_rk_write_only_kexp: assert property (@(posedge clk) disable iff (!rst_n)
        rk_we |-> (state_reg == ST_KEXP && cnt_reg <= 4'(NUM_ROUNDS)))
        else $error("round key write outside key expansion");
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RND) |-> (cnt_reg < 4'(NUM_ROUNDS)))
        else $error("round counter overran");
`endif
endmodule
